// ----- sv/lffe_pkg.sv -----
`default_nettype none

package lffe_pkg;

    localparam int FRAME_W = 16;
    localparam int COUNT_W = 16;
    localparam int MASK_W  = 16;

    localparam logic [FRAME_W-1:0] EMPTY_FRAME  = 16'hFFFF;
    localparam logic [COUNT_W-1:0] EXPIRY_RESET = 16'd10800;

    localparam logic [2:0] VERDICT_TICK       = 3'd0;
    localparam logic [2:0] VERDICT_ACCEPT     = 3'd1;
    localparam logic [2:0] VERDICT_STALE      = 3'd2;
    localparam logic [2:0] VERDICT_WRONG_GAME = 3'd3;
    localparam logic [2:0] VERDICT_RELIABLE   = 3'd4;
    localparam logic [2:0] VERDICT_BAD_TYPE   = 3'd5;

    localparam logic [1:0] OP_PASS   = 2'd0;
    localparam logic [1:0] OP_FILTER = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] CFG_MY_GAME_ID   = 2'd0;
    localparam logic [1:0] CFG_EXPIRY       = 2'd1;
    localparam logic [1:0] CFG_TYPES_IN_USE = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         verdict;
        logic [3:0]         type_index;
        logic [FRAME_W-1:0] frame;
    } job_t;

    typedef struct packed {
        logic [2:0]        verdict;
        logic [MASK_W-1:0] expired_mask;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/lffe_ram.sv -----
`default_nettype none

module lffe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/lffe_fifo.sv -----
`default_nettype none

module lffe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lffe_front.sv -----
`default_nettype none

module lffe_front #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                    cmd,
    input  wire logic [7:0]              game_id,
    input  wire logic [3:0]              type_index,
    input  wire logic [15:0]             frame,
    input  wire logic                    is_reliable,
    input  wire logic [7:0]              my_game_id,
    input  wire logic [4:0]              types_in_use,
    output lffe_pkg::job_t               job
);

    import lffe_pkg::*;

    logic bad_type;

    assign bad_type = ({1'b0, type_index} >= types_in_use)
                   || (32'(type_index) >= SLOT_COUNT);

    always_comb
    begin
        job.type_index = type_index;
        job.frame      = frame;
        job.verdict    = VERDICT_TICK;
        job.op         = OP_PASS;
        if (cmd)
        begin
            job.op = OP_TICK;
        end
        else if (game_id != my_game_id)
        begin
            job.verdict = VERDICT_WRONG_GAME;
        end
        else if (bad_type)
        begin
            job.verdict = VERDICT_BAD_TYPE;
        end
        else if (is_reliable)
        begin
            job.verdict = VERDICT_RELIABLE;
        end
        else
        begin
            job.op = OP_FILTER;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lffe_back.sv -----
`default_nettype none

module lffe_back #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lffe_pkg::job_t  job,
    input  wire logic            job_valid,
    output logic                 job_pop,
    input  wire logic            res_ready,
    output logic                 res_push,
    output lffe_pkg::result_t    res,
    input  wire logic [15:0]     expiry_frames
);

    import lffe_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int EW = FRAME_W + COUNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MSG  = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;

    logic [1:0]            state_reg, state_next;
    job_t                  job_reg, job_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic [MASK_W-1:0]     mask_reg, mask_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [EW-1:0]         ram_wdata, ram_rdata;

    logic [AW-1:0]         slot_addr, cur_addr;
    logic [FRAME_W-1:0]    entry_frame, diff, new_frame;
    logic [COUNT_W-1:0]    entry_count, dec_count, load_count;
    logic                  newer;
    logic [31:0]           slot_num;

    lffe_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_addr   = AW'(job_reg.type_index);
    assign cur_addr    = (state_reg == S_TICK) ? cnt_reg : slot_addr;
    assign entry_frame = valid_reg[cur_addr] ? ram_rdata[EW-1:COUNT_W] : EMPTY_FRAME;
    assign entry_count = valid_reg[cur_addr] ? ram_rdata[COUNT_W-1:0] : '0;
    assign diff        = job_reg.frame - entry_frame;
    assign newer       = (diff != '0) && !diff[FRAME_W-1];
    assign dec_count   = entry_count - COUNT_W'(1);
    assign load_count  = (expiry_frames == '0) ? COUNT_W'(1) : expiry_frames;
    assign slot_num    = 32'(cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        mask_next  = mask_reg;
        valid_next = valid_reg;
        job_pop    = 1'b0;
        res_push   = 1'b0;
        res        = '0;
        ram_we     = 1'b0;
        ram_waddr  = cur_addr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        new_frame  = entry_frame;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid && res_ready)
                begin
                    job_pop  = 1'b1;
                    job_next = job;
                    case (job.op)
                        OP_PASS:
                        begin
                            res_push    = 1'b1;
                            res.verdict = job.verdict;
                        end
                        OP_FILTER:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(job.type_index);
                            state_next = S_MSG;
                        end
                        OP_TICK:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            cnt_next   = '0;
                            mask_next  = '0;
                            state_next = S_TICK;
                        end
                        default:
                        begin
                            res_push    = 1'b1;
                            res.verdict = job.verdict;
                        end
                    endcase
                end
            end
            S_MSG:
            begin
                res_push = 1'b1;
                if ((entry_frame == EMPTY_FRAME) || newer)
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = slot_addr;
                    ram_wdata             = {job_reg.frame, load_count};
                    valid_next[slot_addr] = 1'b1;
                    res.verdict           = VERDICT_ACCEPT;
                end
                else
                begin
                    res.verdict = VERDICT_STALE;
                end
                state_next = S_IDLE;
            end
            S_TICK:
            begin
                if (entry_count != '0)
                begin
                    if (dec_count == '0)
                    begin
                        new_frame = EMPTY_FRAME;
                        if (slot_num < 32'(MASK_W))
                        begin
                            mask_next[slot_num[3:0]] = 1'b1;
                        end
                    end
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg;
                    ram_wdata = {new_frame, dec_count};
                end
                if (slot_num == SLOT_COUNT - 1)
                begin
                    res_push         = 1'b1;
                    res.verdict      = VERDICT_TICK;
                    res.expired_mask = mask_next;
                    state_next       = S_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_reg + AW'(1);
                    cnt_next  = cnt_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        mask_reg <= mask_next;
    end

endmodule

`default_nettype wire

// ----- sv/latest_frame_filter_with_expiry.sv -----
// Freshness filter with aging for received messages, one slot per message type.
// Input channel: an item (cmd, game_id, type_index, frame, is_reliable) is a
// transaction when push is high and full is low. Result channel: the oldest
// result (verdict, expired_mask) is shown while empty is low and is a
// transaction when pop is high. Configuration writes use cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high.
// The front end classifies each item in the cycle it arrives and stores it in
// a two-entry job queue. The back end executes one job at a time against the
// slot memory: wrong game, bad type and reliable messages pass straight to a
// result, an unreliable message takes a memory read, then compare and write,
// and a tick walks the slot memory one slot per cycle. A result passes from
// the job queue through the back end into the output queue before it is shown.
// Results wait in a two-entry output queue; when the receiver stalls, that
// queue fills, the back end stops, the job queue fills and full rises.
// Reset empties both queues, restores the register defaults and marks every
// slot as empty and inactive at once; there is no clearing pass.
`default_nettype none

module latest_frame_filter_with_expiry #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        cmd,
    input  wire logic [7:0]  game_id,
    input  wire logic [3:0]  type_index,
    input  wire logic [15:0] frame,
    input  wire logic        is_reliable,
    output logic             empty,
    input  wire logic        pop,
    output logic      [2:0]  verdict,
    output logic      [15:0] expired_mask,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    import lffe_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    logic [7:0]  my_game_id_reg;
    logic [15:0] expiry_frames_reg;
    logic [4:0]  types_in_use_reg;

    job_t        front_job, back_job;
    logic        job_full, job_empty, job_pop;
    result_t     back_res, out_res;
    logic        res_full, res_push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_game_id_reg    <= '0;
            expiry_frames_reg <= EXPIRY_RESET;
            types_in_use_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MY_GAME_ID:   my_game_id_reg    <= cfg_data[7:0];
                CFG_EXPIRY:       expiry_frames_reg <= cfg_data;
                CFG_TYPES_IN_USE: types_in_use_reg  <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    lffe_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .cmd          (cmd),
        .game_id      (game_id),
        .type_index   (type_index),
        .frame        (frame),
        .is_reliable  (is_reliable),
        .my_game_id   (my_game_id_reg),
        .types_in_use (types_in_use_reg),
        .job          (front_job)
    );

    lffe_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_job),
        .rd_en   (job_pop),
        .rd_data (back_job),
        .full    (job_full),
        .empty   (job_empty)
    );

    assign full = job_full;

    lffe_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (back_job),
        .job_valid     (!job_empty),
        .job_pop       (job_pop),
        .res_ready     (!res_full),
        .res_push      (res_push),
        .res           (back_res),
        .expiry_frames (expiry_frames_reg)
    );

    lffe_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .rd_en   (pop),
        .rd_data (out_res),
        .full    (res_full),
        .empty   (empty)
    );

    assign verdict      = out_res.verdict;
    assign expired_mask = out_res.expired_mask;

endmodule

`default_nettype wire
